// ===== rtl/core/dpcm_pkg.sv =====
// Shared constants for the demand paging clock MMU.
`default_nettype none
package dpcm_pkg;
  localparam int MAX_FRAMES    = 16;
  localparam int MAX_PROCESSES = 8;
  localparam int MAX_PAGES     = 64;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_REG   = 2'd2;
  localparam logic [1:0] OP_FREE  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FAULT   = 3'd1;
  localparam logic [2:0] ST_BOUNDS  = 3'd2;
  localparam logic [2:0] ST_NOTREG  = 3'd3;
  localparam logic [2:0] ST_TOOBIG  = 3'd4;

  localparam logic CFG_LOG2   = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  localparam int LOG2_MIN = 4;
  localparam int LOG2_MAX = 16;
endpackage
`default_nettype wire

// ===== rtl/core/dpcm_page_mem.sv =====
// Page table memory: one synchronous read port, one write port.
`default_nettype none
module dpcm_page_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 7
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata
);
  logic [DW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/demand_paging_clock_mmu_top.sv =====
// Top level of the demand paging MMU with clock page replacement.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    opcode, process_slot, virtual_addr, size_bytes
//  out      out  out_valid/out_stall  status, phys_addr, fault_frame, write_back,
//                                     victim_process, victim_page, avail_frames
//  cfg      in   cfg_we               cfg_index, cfg_data
//
// One word at a time. States per word: register and error words S_DEC, S_OUT;
//   hit S_DEC, S_ACC, S_OUT; a fault on a free frame adds S_INST; a fault with a
//   clock walk passes S_VRD and S_VCHK once per frame visited (at most 2*frames+2
//   visits) before S_INST; free sweeps MAX_PAGES page entries, one cleared a cycle.
// After reset a clearing pass runs through every entry of
// the page memory; in_stall stays high meanwhile.
// A result waits in the output register while out_stall is high; the next word
// is taken in the cycle the result leaves.
`default_nettype none
module demand_paging_clock_mmu_top #(
  parameter int MAX_FRAMES    = dpcm_pkg::MAX_FRAMES,
  parameter int MAX_PROCESSES = dpcm_pkg::MAX_PROCESSES,
  parameter int MAX_PAGES     = dpcm_pkg::MAX_PAGES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [2:0]  process_slot,
  input  wire logic [21:0] virtual_addr,
  input  wire logic [22:0] size_bytes,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [19:0]      phys_addr,
  output logic [3:0]       fault_frame,
  output logic             write_back,
  output logic [2:0]       victim_process,
  output logic [5:0]       victim_page,
  output logic [4:0]       avail_frames
);
  localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int GW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int GCW = $clog2(MAX_PAGES + 1);
  localparam int AW  = PW + GW;
  localparam int EW  = 3 + FW;
  localparam int NCW = $clog2(MAX_FRAMES + 1);
  localparam int KW  = $clog2(2 * MAX_FRAMES + 2);
  localparam int DEPTH = MAX_PROCESSES * MAX_PAGES;

  // page entry layout: {valid, referenced, dirty, frame}
  localparam int B_V = EW - 1;
  localparam int B_R = EW - 2;
  localparam int B_D = EW - 3;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_VRD   = 4'd4;
  localparam logic [3:0] S_VCHK  = 4'd5;
  localparam logic [3:0] S_INST  = 4'd6;
  localparam logic [3:0] S_SWEEP = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state, state_next;
  logic [4:0] lg_reg, nf_reg;
  logic [AW-1:0] clr_addr;

  // word being worked on
  logic [1:0]  op;
  logic [2:0]  slot;
  logic [21:0] va;
  logic [22:0] sz;

  // process and frame tables
  logic [MAX_PROCESSES-1:0] preg;
  logic [GCW-1:0] pcnt [MAX_PROCESSES];
  logic [MAX_FRAMES-1:0] ffree;
  logic [PW-1:0] fown [MAX_FRAMES];
  logic [GW-1:0] fpage [MAX_FRAMES];
  logic [FW-1:0] hand;
  logic [KW-1:0] kcnt;
  logic [GW-1:0] sweep_idx;

  // result register
  logic [2:0]  r_status;
  logic [19:0] r_phys;
  logic [FW-1:0] r_ffr;
  logic r_wb;
  logic [2:0] r_vproc;
  logic [5:0] r_vpage;
  logic [4:0] r_free;

  // page memory, one read and one write port
  logic [AW-1:0] m_raddr, m_waddr;
  logic [EW-1:0] m_rdata, m_wdata;
  logic m_we;
  dpcm_page_mem #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_mem (
    .clk(clk), .raddr(m_raddr), .rdata(m_rdata),
    .we(m_we), .waddr(m_waddr), .wdata(m_wdata)
  );

  // clamped configuration
  logic [4:0] lg;
  logic [NCW-1:0] n;
  always_comb begin
    if (lg_reg < 5'(dpcm_pkg::LOG2_MIN)) lg = 5'(dpcm_pkg::LOG2_MIN);
    else if (lg_reg > 5'(dpcm_pkg::LOG2_MAX)) lg = 5'(dpcm_pkg::LOG2_MAX);
    else lg = lg_reg;
    if (nf_reg == 5'd0) n = NCW'(1);
    else if (32'(nf_reg) > MAX_FRAMES) n = NCW'(MAX_FRAMES);
    else n = NCW'(nf_reg);
  end

  // address split and decode of the held word
  logic [PW-1:0] sidx;
  logic slot_ok, is_live, is_acc, is_free;
  logic [21:0] page_full;
  logic [GW-1:0] page;
  logic [21:0] offs;
  logic in_bounds;
  logic [23:0] reg_pages;
  logic [AW-1:0] e_addr;
  assign sidx = PW'(slot);
  assign slot_ok = (32'(slot) < MAX_PROCESSES);
  assign page_full = va >> lg;
  assign page = page_full[GW-1:0];
  assign offs = va & ((22'd1 << lg) - 22'd1);
  assign in_bounds = (page_full < 22'(pcnt[sidx])) && (page_full < 22'(MAX_PAGES));
  assign reg_pages = (24'(sz) + ((24'd1 << lg) - 24'd1)) >> lg;
  assign e_addr = {sidx, page};
  assign is_live = slot_ok && preg[sidx];
  assign is_acc = (op[1] == 1'b0) && is_live && in_bounds;
  assign is_free = (op == dpcm_pkg::OP_FREE) && is_live;

  // lowest free managed frame, free count
  logic [NCW-1:0] free_cnt;
  logic has_free;
  logic [FW-1:0] low_free;
  always_comb begin
    free_cnt = '0; has_free = 1'b0; low_free = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (i < 32'(n) && ffree[i]) begin
        has_free = 1'b1; low_free = FW'(i);
      end
    end
    for (int i = 0; i < MAX_FRAMES; i++)
      if (i < 32'(n) && ffree[i]) free_cnt = free_cnt + NCW'(1);
  end

  // clock candidate: owner registered, page in range, entry maps back to hand
  logic [PW-1:0] h_own;
  logic [GW-1:0] h_pg;
  logic h_pre_ok, h_mem_ok, v_ok, v_stop;
  logic [FW-1:0] hand_inc;
  logic [KW-1:0] kcnt_lim;
  assign h_own = fown[hand];
  assign h_pg = fpage[hand];
  assign h_pre_ok = preg[h_own] && (32'(h_pg) < 32'(pcnt[h_own]));
  assign h_mem_ok = m_rdata[B_V] && (m_rdata[FW-1:0] == hand);
  assign v_ok = h_pre_ok && h_mem_ok;
  // walk ends after 2n+1 steps at most
  assign kcnt_lim = KW'(2 * 32'(n) + 1);
  assign v_stop = !v_ok || !m_rdata[B_R] || (kcnt == kcnt_lim);
  assign hand_inc = (32'(hand) + 1 >= 32'(n)) ? '0 : FW'(32'(hand) + 1);

  // a new word enters as the previous result leaves
  logic in_take;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign in_take = in_valid && !in_stall;

  logic [EW-1:0] hit_ent, clr_ent;
  always_comb begin
    hit_ent = m_rdata; hit_ent[B_R] = 1'b1;
    if (op == dpcm_pkg::OP_WRITE) hit_ent[B_D] = 1'b1;
    clr_ent = m_rdata; clr_ent[B_R] = 1'b0;
  end

  always_comb begin
    state_next = state;
    m_raddr = e_addr; m_we = 1'b0; m_waddr = e_addr; m_wdata = '0;
    case (state)
      S_CLR: begin
        m_we = 1'b1; m_waddr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: if (in_take) state_next = S_DEC;
      S_DEC: begin
        // entry read issued here, data in S_ACC
        if (is_free) state_next = S_SWEEP;
        else if (is_acc) state_next = S_ACC;
        else state_next = S_OUT;
      end
      S_ACC: begin
        if (m_rdata[B_V]) begin
          m_we = 1'b1; m_wdata = hit_ent; state_next = S_OUT;
        end else if (has_free) begin
          state_next = S_INST;
        end else begin
          state_next = S_VRD;
        end
      end
      S_VRD: begin
        m_raddr = {h_own, h_pg};
        state_next = S_VCHK;
      end
      S_VCHK: begin
        m_waddr = {h_own, h_pg};
        if (v_ok) begin
          m_we = 1'b1;
          m_wdata = v_stop ? '0 : clr_ent;
        end
        state_next = v_stop ? S_INST : S_VRD;
      end
      S_INST: begin
        m_we = 1'b1; m_wdata = {1'b1, 1'b1, 1'b0, r_ffr};
        state_next = S_OUT;
      end
      S_SWEEP: begin
        m_we = 1'b1; m_waddr = {sidx, sweep_idx};
        if (sweep_idx == GW'(MAX_PAGES - 1)) state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_addr <= '0; lg_reg <= 5'd8; nf_reg <= 5'd16;
      preg <= '0; ffree <= '1; hand <= '0; out_valid <= 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) pcnt[i] <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        fown[i] <= '0; fpage[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == dpcm_pkg::CFG_LOG2) lg_reg <= cfg_data;
        else nf_reg <= cfg_data;
      end
      if (state == S_OUT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLR: clr_addr <= clr_addr + AW'(1);
        S_IDLE: if (in_take) begin
          op <= opcode; slot <= process_slot; va <= virtual_addr;
          sz <= size_bytes;
          r_status <= dpcm_pkg::ST_OK; r_phys <= '0; r_ffr <= '0; r_wb <= 1'b0;
          r_vproc <= '0; r_vpage <= '0;
        end
        S_DEC: begin
          sweep_idx <= '0;
          if (op == dpcm_pkg::OP_REG) begin
            // entries of a never registered slot are still clear
            if (!slot_ok) r_status <= dpcm_pkg::ST_NOTREG;
            else if (!preg[sidx]) begin
              if (reg_pages > 24'(MAX_PAGES)) r_status <= dpcm_pkg::ST_TOOBIG;
              else begin
                preg[sidx] <= 1'b1; pcnt[sidx] <= GCW'(reg_pages);
              end
            end
          end else if (!is_live) begin
            r_status <= dpcm_pkg::ST_NOTREG;
          end else if (op == dpcm_pkg::OP_FREE) begin
            for (int i = 0; i < MAX_FRAMES; i++)
              if (!ffree[i] && fown[i] == sidx) begin
                ffree[i] <= 1'b1; fown[i] <= '0; fpage[i] <= '0;
              end
          end else if (!in_bounds) begin
            r_status <= dpcm_pkg::ST_BOUNDS;
          end
        end
        S_ACC: begin
          if (m_rdata[B_V]) begin
            r_phys <= 20'((22'(m_rdata[FW-1:0]) << lg) | offs);
          end else begin
            r_status <= dpcm_pkg::ST_FAULT;
            if (has_free) begin
              r_ffr <= low_free;
            end else begin
              kcnt <= '0;
              if (32'(hand) >= 32'(n)) hand <= '0;
            end
          end
        end
        S_VCHK: begin
          if (v_stop) begin
            r_ffr <= hand;
            if (v_ok && m_rdata[B_D]) begin
              r_wb <= 1'b1;
              r_vproc <= 3'(h_own); r_vpage <= 6'(h_pg);
            end
          end else begin
            hand <= hand_inc; kcnt <= kcnt + KW'(1);
          end
        end
        S_INST: begin
          ffree[r_ffr] <= 1'b0; fown[r_ffr] <= sidx; fpage[r_ffr] <= page;
        end
        S_SWEEP: sweep_idx <= sweep_idx + GW'(1);
        S_OUT: r_free <= 5'(free_cnt);
        default: ;
      endcase
    end
  end

  assign status = r_status;
  assign phys_addr = r_phys;
  assign fault_frame = 4'(r_ffr);
  assign write_back = r_wb;
  assign victim_process = r_vproc;
  assign victim_page = r_vpage;
  assign avail_frames = r_free;
endmodule
`default_nettype wire
